FILE: rtl/arc_pkg.sv
package arc_pkg;

  // Command codes carried in the input tuser
  typedef enum logic [1:0] {
    CMD_FRAME   = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_REQUEST = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  // Result status codes carried in the output tuser
  localparam logic [2:0] ST_DROPPED  = 3'd0;
  localparam logic [2:0] ST_NOT_US   = 3'd1;
  localparam logic [2:0] ST_LEARNED  = 3'd2;
  localparam logic [2:0] ST_REPLIED  = 3'd3;
  localparam logic [2:0] ST_REQ_SENT = 3'd4;
  localparam logic [2:0] ST_TICK     = 3'd5;

  // Opcode of the transmitted frame
  localparam logic [1:0] TX_OP_NONE    = 2'd0;
  localparam logic [1:0] TX_OP_REQUEST = 2'd1;
  localparam logic [1:0] TX_OP_REPLY   = 2'd2;

  // Minimum length and ARP header values that a frame must carry, and the request opcode
  localparam logic [10:0] MIN_FRAME_LEN = 11'd42;
  localparam logic [15:0] HTYPE_ETH     = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  HLEN_ETH      = 8'h06;
  localparam logic [7:0]  PLEN_IPV4     = 8'h04;
  localparam logic [15:0] ARP_OP_REQ    = 16'h0001;

  localparam logic [47:0] BCAST_MAC     = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] AGE_MAX       = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RST   = 16'd600;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOCAL_IP  = 2'd0;
  localparam logic [1:0] CFG_LOCAL_MAC = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 120;
  localparam int RES_W      = 117;
  localparam int CFG_DATA_W = 48;

  // One cache entry as stored in memory
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [15:0] age;
  } entry_t;

  // Write request from the control FSM to the cache store
  typedef struct packed {
    logic   wr_en;
    logic   set_vld;
    logic   clr_vld;
    entry_t data;
  } store_cmd_t;

  // Result payload, first field in the highest bits
  typedef struct packed {
    logic        table_full;
    logic        refreshed;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
    logic [47:0] target_mac;
    logic [1:0]  opcode;
    logic        transmit;
  } result_t;

endpackage

FILE: rtl/arp_responder_cache.sv
// Channel   Direction  tdata                          tuser
// in_       slave      parsed ARP frame fields        command
// out_      master     transmit and frame fields      status
// cfg_      write      register value (48 bits)       -
//
// A frame is accepted, then the entry memory is scanned at one read per cycle
// behind a registered read, then comes an update step and the output register
// is loaded. A tick skips the update step. A send request or a dropped frame
// goes straight from acceptance to the load of the output register. The scan
// of every entry through the one read port sets the length of frames and ticks.
// Reset clears every valid bit at once; no clearing pass.
// A stalled output holds the result; the input is taken again once loaded.
module arp_responder_cache
  import arc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // frame_length, hardware_type, protocol_type, hw_addr_len, proto_addr_len,
  // opcode, sender_mac, sender_ip, target_ip
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // transmit, out_opcode, out_target_mac, out_target_ip, out_sender_ip,
  // refreshed, table_full
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [2:0]            out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ADDR_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t          state_r;
  logic [31:0]     local_ip_r;
  logic [47:0]     local_mac_r;
  logic [15:0]     timeout_r;

  cmd_t            cmd_r;
  logic [15:0]     opc_r;
  logic [47:0]     smac_r;
  logic [31:0]     spa_r;
  logic [31:0]     tpa_r;

  logic [CNT_W-1:0]  issue_cnt_r;
  logic              pv_r;
  logic [ADDR_W-1:0] paddr_r;
  logic              hit_found_r;
  logic [ADDR_W-1:0] hit_idx_r;
  logic              free_found_r;
  logic [ADDR_W-1:0] free_idx_r;

  result_t         res_r;
  logic [2:0]      status_r;
  logic            out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [2:0]      out_tuser_r;

  // Input fields
  logic [10:0] in_flen;
  logic [15:0] in_hrd;
  logic [15:0] in_pro;
  logic [7:0]  in_hln;
  logic [7:0]  in_pln;
  logic [15:0] in_opc;
  logic [47:0] in_smac;
  logic [31:0] in_spa;
  logic [31:0] in_tpa;
  logic        fmt_ok;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;
  logic              rd_vld;
  logic [ADDR_W-1:0] wr_addr;
  store_cmd_t        store_cmd;
  logic [15:0]       age_inc;
  logic              scan_last;
  logic              for_us;
  result_t           upd_res;
  logic [2:0]        upd_status;
  result_t           req_res;

  assign in_flen = in_tdata[10:0];
  assign in_hrd  = in_tdata[26:11];
  assign in_pro  = in_tdata[42:27];
  assign in_hln  = in_tdata[50:43];
  assign in_pln  = in_tdata[58:51];
  assign in_opc  = in_tdata[74:59];
  assign in_smac = in_tdata[122:75];
  assign in_spa  = in_tdata[154:123];
  assign in_tpa  = in_tdata[186:155];

  assign fmt_ok = (in_flen >= MIN_FRAME_LEN) && (in_hrd == HTYPE_ETH) &&
                  (in_hln == HLEN_ETH) && (in_pro == PTYPE_IPV4) &&
                  (in_pln == PLEN_IPV4);

  assign in_tready = (state_r == S_IDLE);

  // Issue one memory read per cycle during the scan
  assign rd_en     = (state_r == S_SCAN) && (issue_cnt_r < CNT_W'(CACHE_ENTRIES));
  assign rd_addr   = issue_cnt_r[ADDR_W-1:0];
  assign scan_last = pv_r && (paddr_r == ADDR_W'(CACHE_ENTRIES - 1));
  assign age_inc   = (rd_data.age == AGE_MAX) ? rd_data.age : rd_data.age + 16'd1;
  assign for_us    = (tpa_r == local_ip_r);

  arc_store #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .ADDR_W        (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rd_vld  (rd_vld),
    .wr_addr (wr_addr),
    .cmd     (store_cmd)
  );

  // Write back aged entries during a tick, refresh or learn after a frame scan
  always_comb begin
    store_cmd = '0;
    wr_addr   = paddr_r;
    case (state_r)
      S_SCAN: begin
        if (pv_r && (cmd_r == CMD_TICK) && rd_vld) begin
          store_cmd.wr_en    = 1'b1;
          store_cmd.data.ip  = rd_data.ip;
          store_cmd.data.mac = rd_data.mac;
          store_cmd.data.age = age_inc;
          store_cmd.clr_vld  = (age_inc > timeout_r);
        end
      end
      S_UPDATE: begin
        store_cmd.data.ip  = spa_r;
        store_cmd.data.mac = smac_r;
        store_cmd.data.age = '0;
        if (hit_found_r) begin
          store_cmd.wr_en = 1'b1;
          wr_addr         = hit_idx_r;
        end else if (for_us && free_found_r) begin
          store_cmd.wr_en   = 1'b1;
          store_cmd.set_vld = 1'b1;
          wr_addr           = free_idx_r;
        end
      end
      default: begin
        store_cmd = '0;
      end
    endcase
  end

  // Build the result of a scanned frame
  always_comb begin
    upd_res           = '0;
    upd_res.refreshed = hit_found_r;
    upd_status        = ST_NOT_US;
    if (for_us) begin
      upd_res.table_full = !hit_found_r && !free_found_r;
      if (opc_r == ARP_OP_REQ) begin
        upd_status         = ST_REPLIED;
        upd_res.transmit   = 1'b1;
        upd_res.opcode     = TX_OP_REPLY;
        upd_res.target_mac = smac_r;
        upd_res.target_ip  = spa_r;
        upd_res.sender_ip  = local_ip_r;
      end else begin
        upd_status = ST_LEARNED;
      end
    end
  end

  // Broadcast request built straight from the input
  always_comb begin
    req_res            = '0;
    req_res.transmit   = 1'b1;
    req_res.opcode     = TX_OP_REQUEST;
    req_res.target_mac = BCAST_MAC;
    req_res.target_ip  = in_tpa;
    req_res.sender_ip  = in_spa;
  end

  // Control FSM, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      pv_r         <= 1'b0;
      issue_cnt_r  <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      local_ip_r   <= '0;
      local_mac_r  <= '0;
      timeout_r    <= TIMEOUT_RST;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_LOCAL_IP:  local_ip_r  <= cfg_wdata[31:0];
          CFG_LOCAL_MAC: local_mac_r <= cfg_wdata;
          CFG_TIMEOUT:   timeout_r   <= cfg_wdata[15:0];
          default:       ;
        endcase
      end

      pv_r    <= rd_en;
      paddr_r <= rd_addr;

      // Raise valid when a result is loaded, drop it once taken
      if ((state_r == S_DONE) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r        <= cmd_t'(in_tuser);
            opc_r        <= in_opc;
            smac_r       <= in_smac;
            spa_r        <= in_spa;
            tpa_r        <= in_tpa;
            issue_cnt_r  <= '0;
            hit_found_r  <= 1'b0;
            free_found_r <= 1'b0;
            case (cmd_t'(in_tuser))
              CMD_FRAME: begin
                if (fmt_ok) begin
                  state_r <= S_SCAN;
                end else begin
                  res_r    <= '0;
                  status_r <= ST_DROPPED;
                  state_r  <= S_DONE;
                end
              end
              CMD_TICK: begin
                state_r <= S_SCAN;
              end
              CMD_REQUEST: begin
                res_r    <= req_res;
                status_r <= ST_REQ_SENT;
                state_r  <= S_DONE;
              end
              default: begin
                res_r    <= '0;
                status_r <= ST_DROPPED;
                state_r  <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            issue_cnt_r <= issue_cnt_r + CNT_W'(1);
          end
          // track first matching entry and first free slot
          if (pv_r && (cmd_r == CMD_FRAME)) begin
            if (rd_vld && (rd_data.ip == spa_r) && !hit_found_r) begin
              hit_found_r <= 1'b1;
              hit_idx_r   <= paddr_r;
            end
            if (!rd_vld && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= paddr_r;
            end
          end
          if (scan_last) begin
            if (cmd_r == CMD_FRAME) begin
              state_r <= S_UPDATE;
            end else begin
              res_r    <= '0;
              status_r <= ST_TICK;
              state_r  <= S_DONE;
            end
          end
        end
        S_UPDATE: begin
          res_r    <= upd_res;
          status_r <= upd_status;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {{(OUT_DATA_W - RES_W){1'b0}}, res_r};
            out_tuser_r  <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Sender MAC of transmitted frames goes out on the frame path, not here
  logic unused_mac;
  assign unused_mac = ^local_mac_r;

endmodule

FILE: rtl/arc_store.sv
module arc_store
  import arc_pkg::*;
#(
  parameter int CACHE_ENTRIES = 16,
  parameter int ADDR_W        = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data,
  output logic              rd_vld,
  input  logic [ADDR_W-1:0] wr_addr,
  input  store_cmd_t        cmd
);

  entry_t                   mem [CACHE_ENTRIES];
  entry_t                   rd_data_r;
  logic                     rd_vld_r;
  logic [CACHE_ENTRIES-1:0] vld_r;

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.wr_en) begin
      if (cmd.set_vld) begin
        vld_r[wr_addr] <= 1'b1;
      end else if (cmd.clr_vld) begin
        vld_r[wr_addr] <= 1'b0;
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_vld  = rd_vld_r;

endmodule
